// ===== src/ebms_pkg.sv =====
// Shared types, codes and sizes of the embedding best-match search block.
`timescale 1ns / 1ps
package ebms_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int VECTOR_LEN_DEF  = 512;
   localparam int CMD_DEPTH       = 4;

   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_WRITE  = 3'd1;
   localparam logic [2:0] ACT_DELETE = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_QUERY  = 3'd4;

   localparam logic signed [15:0] SIM_NONE = 16'sh8000;
   localparam logic signed [15:0] SIM_TOP  = 16'sh7fff;

   typedef struct packed {
      logic [2:0]         action;
      logic [5:0]         slot;
      logic [8:0]         element_index;
      logic signed [15:0] element_value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [5:0]         result_slot;
      logic               has_best;
      logic               matched;
      logic signed [15:0] similarity;
   } rsp_type;

   typedef enum logic [2:0] {
      K_APPEND,
      K_WRITE,
      K_DELETE,
      K_CLEAR,
      K_QUERY
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [5:0]         slot;
      logic [8:0]         eidx;
      logic signed [15:0] val;
      logic               last;
      logic               eok;
   } cmd_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qsts_type;

endpackage

// ===== src/ebms_fifo.sv =====
// Short command queue between the front and the engine.
`timescale 1ns / 1ps
module ebms_fifo (
   input  logic             clock,
   input  logic             reset,
   input  ebms_pkg::qctl_type ctl,
   input  ebms_pkg::cmd_type  wr_cmd,
   output ebms_pkg::qsts_type sts,
   output ebms_pkg::cmd_type  rd_cmd
);
   import ebms_pkg::*;

   localparam int PW = $clog2(CMD_DEPTH);
   localparam int NW = $clog2(CMD_DEPTH + 1);

   cmd_type         mem [CMD_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [NW-1:0]   n_ff, n_in;
   logic            do_push, do_pop;

   assign sts.full  = (n_ff == NW'(CMD_DEPTH));
   assign sts.empty = (n_ff == '0);
   assign rd_cmd    = mem[rp_ff];
   assign do_push   = ctl.push && !sts.full;
   assign do_pop    = ctl.pop && !sts.empty;

   always_comb begin
      wp_in = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in = do_pop ? rp_ff + 1'b1 : rp_ff;
      n_in  = n_ff;
      if (do_push && !do_pop) begin
         n_in = n_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

endmodule

// ===== src/ebms_front.sv =====
// Front end: decodes each input word and queues the ones that have an effect.
`timescale 1ns / 1ps
module ebms_front #(
   parameter int MAX_ENTRIES = ebms_pkg::MAX_ENTRIES_DEF,
   parameter int VECTOR_LEN  = ebms_pkg::VECTOR_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ebms_pkg::req_type req_word,
   input  logic              cmd_pop,
   output logic              cmd_empty,
   output ebms_pkg::cmd_type cmd
);
   import ebms_pkg::*;

   cmd_type  dec;
   logic     keep;
   qctl_type ctl;
   qsts_type sts;
   logic     slot_ok;

   assign slot_ok = (32'(req_word.slot) < MAX_ENTRIES);

   always_comb begin
      dec.slot = req_word.slot;
      dec.eidx = req_word.element_index;
      dec.val  = req_word.element_value;
      dec.last = req_word.last;
      dec.eok  = (32'(req_word.element_index) < VECTOR_LEN);
      dec.kind = K_CLEAR;
      keep     = 1'b1;
      case (req_word.action)
         ACT_APPEND: dec.kind = K_APPEND;
         ACT_WRITE: begin
            dec.kind = K_WRITE;
            keep     = slot_ok && dec.eok;
         end
         ACT_DELETE: begin
            dec.kind = K_DELETE;
            keep     = slot_ok;
         end
         ACT_CLEAR: dec.kind = K_CLEAR;
         ACT_QUERY: dec.kind = K_QUERY;
         default: keep = 1'b0;
      endcase
   end

   // Words without any effect are taken and dropped here.
   assign ctl.push  = req_push && keep;
   assign ctl.pop   = cmd_pop;
   assign req_full  = sts.full;
   assign cmd_empty = sts.empty;

   ebms_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .wr_cmd (dec),
      .sts    (sts),
      .rd_cmd (cmd)
   );

endmodule

// ===== src/ebms_engine.sv =====
// Back end: entry storage, dot-product accumulation, best-entry scan, root and divide.
`timescale 1ns / 1ps
module ebms_engine #(
   parameter int MAX_ENTRIES = ebms_pkg::MAX_ENTRIES_DEF,
   parameter int VECTOR_LEN  = ebms_pkg::VECTOR_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   input  ebms_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   input  logic signed [15:0]        threshold,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output ebms_pkg::rsp_type         rsp_word
);
   import ebms_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int VW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
   localparam int AW = EW + VW;
   localparam logic [CW-1:0] ME_C = CW'(MAX_ENTRIES);
   localparam logic [5:0] ROOT_LAST = 6'd27;
   localparam logic [5:0] DIV_LAST  = 6'd48;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MAC    = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_ROOT   = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_FIN    = 7'b0100000,
      S_RESULT = 7'b1000000
   } state_type;

   logic signed [15:0] entry_mem [2**AW];
   logic signed [40:0] dot_mem [MAX_ENTRIES];

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [MAX_ENTRIES-1:0] act_ff, act_in, dv_ff, dv_in;
   logic [39:0]        norm_ff, norm_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic [EW-1:0]      s1_idx_ff, s1_idx_in, s2_idx_ff, s2_idx_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [40:0] dd_ff, dd_in;
   logic signed [15:0] eq_ff;
   logic signed [40:0] dq_ff;
   logic               found_ff, found_in;
   logic signed [40:0] best_ff, best_in;
   logic [EW-1:0]      bidx_ff, bidx_in;
   logic [55:0]        op_ff, op_in;
   logic [29:0]        rem_ff, rem_in;
   logic [27:0]        root_ff, root_in;
   logic [5:0]         step_ff, step_in;
   logic [48:0]        dvd_ff, dvd_in;
   logic [27:0]        drem_ff, drem_in;
   logic [48:0]        q_ff, q_in;
   rsp_type            res_ff, res_in, out_ff, out_in;
   logic               out_v_ff, out_v_in;

   logic               e_we, d_we;
   logic [AW-1:0]      e_wa, e_ra;
   logic [EW-1:0]      d_ra;
   logic signed [40:0] d_wd, dval;
   logic signed [41:0] dsum;
   logic [40:0]        nsum;
   logic [31:0]        sq;
   logic [31:0]        rt, rtrial;
   logic [28:0]        dt;
   logic signed [15:0] s;
   logic               has;
   logic [40:0]        bmag;

   assign rsp_empty = !out_v_ff;
   assign rsp_word  = out_ff;

   assign sq    = 32'(cur_ff.val * cur_ff.val);
   assign nsum  = {1'b0, norm_ff} + 41'(sq);
   assign dval  = dv_ff[s1_idx_ff] ? dq_ff : '0;
   assign dsum  = 42'(dd_ff) + 42'(p_ff);
   assign rt     = {rem_ff, op_ff[55:54]};
   assign rtrial = {2'b00, root_ff, 2'b01};
   assign dt     = {drem_ff, dvd_ff[48]};
   assign bmag   = best_ff[40] ? 41'(-best_ff) : 41'(best_ff);

   always_comb begin
      if (dsum[41] != dsum[40]) begin
         d_wd = dsum[41] ? {1'b1, 40'd0} : {1'b0, {40{1'b1}}};
      end else begin
         d_wd = dsum[40:0];
      end
   end

   // Quotient saturation to Q1.15; a negative best dot gives a negative result.
   always_comb begin
      if (best_ff[40]) begin
         s = (q_ff >= 49'd32768) ? SIM_NONE : 16'(-$signed({1'b0, q_ff[14:0]}));
      end else begin
         s = (q_ff > 49'd32767) ? SIM_TOP : $signed(q_ff[15:0]);
      end
      has = found_ff && (s != SIM_NONE);
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      act_in    = act_ff;
      dv_in     = dv_ff;
      norm_in   = norm_ff;
      iss_in    = iss_ff;
      s1_v_in   = 1'b0;
      s1_idx_in = s1_idx_ff;
      s2_v_in   = 1'b0;
      s2_idx_in = s1_idx_ff;
      p_in      = p_ff;
      dd_in     = dd_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      op_in     = op_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      drem_in   = drem_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      out_v_in  = rsp_pop ? 1'b0 : out_v_ff;
      cmd_pop   = 1'b0;
      e_we      = 1'b0;
      e_wa      = {EW'(cmd.slot), VW'(cmd.eidx)};
      e_ra      = {iss_ff[EW-1:0], VW'(cur_ff.eidx)};
      d_we      = 1'b0;
      d_ra      = iss_ff[EW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               iss_in  = '0;
               case (cmd.kind)
                  K_APPEND: begin
                     res_in = '0;
                     if (cnt_ff >= ME_C) begin
                        res_in.status = 1'b1;
                     end else begin
                        act_in[cnt_ff[EW-1:0]] = 1'b1;
                        res_in.result_slot     = 6'(cnt_ff);
                        cnt_in                 = cnt_ff + 1'b1;
                     end
                     state_in = S_RESULT;
                  end
                  K_WRITE: e_we = 1'b1;
                  K_DELETE: act_in[EW'(cmd.slot)] = 1'b0;
                  K_CLEAR: cnt_in = '0;
                  K_QUERY: state_in = S_MAC;
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_MAC: begin
            if (!cur_ff.eok) begin
               state_in = cur_ff.last ? S_SCAN : S_IDLE;
               found_in = 1'b0;
               best_in  = '0;
               bidx_in  = '0;
            end else begin
               if (iss_ff == '0 && !s1_v_ff && !s2_v_ff) begin
                  norm_in = nsum[40] ? {40{1'b1}} : nsum[39:0];
               end
               // Three-stage walk over the entries: read, multiply, accumulate.
               if (iss_ff < ME_C) begin
                  s1_v_in   = 1'b1;
                  s1_idx_in = iss_ff[EW-1:0];
                  iss_in    = iss_ff + 1'b1;
               end
               if (s1_v_ff) begin
                  s2_v_in = 1'b1;
                  p_in    = cur_ff.val * eq_ff;
                  dd_in   = dval;
               end
               if (s2_v_ff) begin
                  d_we             = 1'b1;
                  dv_in[s2_idx_ff] = 1'b1;
               end
               if (iss_ff == ME_C && !s1_v_ff && !s2_v_ff) begin
                  iss_in   = '0;
                  state_in = cur_ff.last ? S_SCAN : S_IDLE;
                  found_in = 1'b0;
                  best_in  = '0;
                  bidx_in  = '0;
               end
            end
         end

         S_SCAN: begin
            if (iss_ff < cnt_ff) begin
               s1_v_in   = 1'b1;
               s1_idx_in = iss_ff[EW-1:0];
               iss_in    = iss_ff + 1'b1;
            end
            if (s1_v_ff && act_ff[s1_idx_ff] && (!found_ff || dval > best_ff)) begin
               found_in = 1'b1;
               best_in  = dval;
               bidx_in  = s1_idx_ff;
            end
            if (iss_ff >= cnt_ff && !s1_v_ff) begin
               op_in   = {norm_ff, 16'd0};
               rem_in  = '0;
               root_in = '0;
               step_in = '0;
               q_in    = '0;
               // A zero norm means an all-zero query, so a found best entry gets similarity zero.
               state_in = (norm_ff == '0 || !found_ff) ? S_FIN : S_ROOT;
            end
         end

         S_ROOT: begin
            if (rt >= rtrial) begin
               rem_in  = 30'(rt - rtrial);
               root_in = {root_ff[26:0], 1'b1};
            end else begin
               rem_in  = rt[29:0];
               root_in = {root_ff[26:0], 1'b0};
            end
            op_in   = {op_ff[53:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               dvd_in   = {bmag[40:0], 8'd0};
               drem_in  = '0;
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            if (dt >= {1'b0, root_ff}) begin
               drem_in = 28'(dt - {1'b0, root_ff});
               q_in    = {q_ff[47:0], 1'b1};
            end else begin
               drem_in = dt[27:0];
               q_in    = {q_ff[47:0], 1'b0};
            end
            dvd_in  = {dvd_ff[47:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            res_in.status      = 1'b0;
            res_in.result_slot = has ? 6'(bidx_ff) : 6'd0;
            res_in.has_best    = has;
            res_in.matched     = has && (s >= threshold);
            res_in.similarity  = has ? s : SIM_NONE;
            dv_in              = '0;
            norm_in            = '0;
            state_in           = S_RESULT;
         end

         S_RESULT: begin
            if (!out_v_ff || rsp_pop) begin
               out_in   = res_ff;
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         entry_mem[e_wa] <= cmd.val;
      end
      eq_ff <= entry_mem[e_ra];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dot_mem[s2_idx_ff] <= d_wd;
      end
      dq_ff <= dot_mem[d_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         act_ff   <= '0;
         dv_ff    <= '0;
         norm_ff  <= '0;
         iss_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         act_ff   <= act_in;
         dv_ff    <= dv_in;
         norm_ff  <= norm_in;
         iss_ff   <= iss_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
      p_ff      <= p_in;
      dd_ff     <= dd_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      bidx_ff   <= bidx_in;
      op_ff     <= op_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      step_ff   <= step_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      q_ff      <= q_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ME_C)
      else $error("entry count beyond capacity");

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |=> dv_ff == '0 && norm_ff == '0)
      else $error("query sums not cleared after finish");

   a_div_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> root_ff != '0)
      else $error("division by a zero root");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESULT && out_v_ff && !rsp_pop |=> state_ff == S_RESULT)
      else $error("result lost while output word waits");

endmodule

// ===== src/embedding_best_match_search.sv =====
// Top level of the embedding best-match search block.
//
// Input words arrive on req_word and are taken when req_push is high and
// req_full is low; result words leave on rsp_word while rsp_empty is low and
// are taken with rsp_pop. The threshold register is written through
// csr_write_enable and csr_write_data.
// A four-word command queue parts the decoder from the engine, so input is
// taken while the engine works or while a result waits to be popped.
// Write, delete and clear give no result; an append gives a result.
// Each query element runs a multiply-accumulate walk over all MAX_ENTRIES
// entry slots. The last element adds a scan of the stored entries, 28
// square-root steps, 49 division steps and the posting of the result.
// Reset empties the queue and the database, and sets the threshold to 0.5.
// While the result word is not popped the engine holds the next result and
// the queue fills, after which req_full rises.
`timescale 1ns / 1ps
module embedding_best_match_search #(
   parameter int MAX_ENTRIES = ebms_pkg::MAX_ENTRIES_DEF,
   parameter int VECTOR_LEN  = ebms_pkg::VECTOR_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  ebms_pkg::req_type  req_word,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ebms_pkg::rsp_type  rsp_word,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);
   import ebms_pkg::*;

   localparam logic signed [15:0] THRESH_RESET = 16'sd16384;

   logic signed [15:0] thr_ff;
   cmd_type            cmd;
   logic               cmd_empty, cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= $signed(csr_write_data);
      end
   end

   ebms_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VECTOR_LEN  (VECTOR_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd       (cmd)
   );

   ebms_engine #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VECTOR_LEN  (VECTOR_LEN)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .threshold (thr_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule
